// ----- hdl/gf2mmr_pkg.sv -----
`default_nettype none

package gf2mmr_pkg;

  // field and exponent sizing
  localparam int unsigned DEGREE     = 16;
  localparam int unsigned EXP_BITS   = 32;
  // port field widths
  localparam int unsigned EXPONENT_W = 32;
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned TAPS_W     = 16;
  localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(45);

  // multiplier bits consumed per cycle by the shared step unit
  localparam int unsigned STEP_BITS = 8;
  localparam int unsigned NCHUNK    = (DEGREE + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned CHUNK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned BIT_IDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  typedef logic [DEGREE-1:0] elem_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // operands of one multiply step
  typedef struct packed {
    elem_t                part;
    elem_t                base;
    logic [STEP_BITS-1:0] bits;
    elem_t                taps;
    logic                 do_x;
  } step_req_t;

  // multiply by x modulo the field polynomial
  function automatic elem_t times_x(elem_t a, elem_t taps);
    elem_t r;
    r = a << 1;
    if (a[DEGREE-1]) begin
      r = r ^ taps;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gf2mmr_if.sv -----
`default_nettype none

interface gf2mmr_in_if import gf2mmr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [EXPONENT_W-1:0] exponent;
  logic                  last_term;

  modport source (output valid, output exponent, output last_term, input ready);
  modport sink (input valid, input exponent, input last_term, output ready);
endinterface

interface gf2mmr_out_if import gf2mmr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] field_element;

  modport source (output valid, output field_element, input ready);
  modport sink (input valid, input field_element, output ready);
endinterface

`default_nettype wire

// ----- hdl/gf2mmr_mul_step.sv -----
`default_nettype none

module gf2mmr_mul_step import gf2mmr_pkg::*; (
  input  step_req_t req_i,
  output elem_t     part_o
);

  always_comb begin
    elem_t r;
    r = req_i.part;
    // msb-first shift-and-add over one chunk of the multiplier
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      r = times_x(r, req_i.taps);
      if (req_i.bits[i]) begin
        r = r ^ req_i.base;
      end
    end
    if (req_i.do_x) begin
      r = times_x(r, req_i.taps);
    end
    part_o = r;
  end

endmodule

`default_nettype wire

// ----- hdl/gf2m_monomial_sum_reducer_unit.sv -----
`default_nettype none

// Sums x^e modulo x^16 + poly_taps over GF(2) for a stream of exponent terms and
// returns the sum on the term marked last, clearing it for the next sum. Each
// term is worked by left-to-right square-and-multiply over all 32 exponent bits
// on one shared shift-and-add multiply step that takes 8 multiplier bits per
// cycle, so a square is worked chunk by chunk and the optional multiply by x
// rides on the last chunk. A term is taken, squared once per exponent bit and
// then folded into the sum; term ready is low meanwhile. A finished sum waits
// in an output register, so a new term is taken while it is still pending;
// only a second finished sum stalls behind it. Write poly_taps only while the
// block is idle.
module gf2m_monomial_sum_reducer_unit import gf2mmr_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [TAPS_W-1:0] cfg_wdata_i,
  gf2mmr_in_if.sink         term_i,
  gf2mmr_out_if.source      result_o
);

  localparam int unsigned BPAD_W = NCHUNK * STEP_BITS;

  state_e                state_q, state_d;
  logic [TAPS_W-1:0]     taps_q;
  elem_t                 acc_q, acc_d;
  elem_t                 base_q, base_d;
  elem_t                 part_q, part_d;
  logic [EXP_BITS-1:0]   exp_q, exp_d;
  logic                  last_q, last_d;
  logic [BIT_IDX_W-1:0]  bit_q, bit_d;
  logic [CHUNK_W-1:0]    chunk_q, chunk_d;
  logic                  out_valid_q, out_valid_d;
  logic [FIELD_W-1:0]    out_data_q, out_data_d;

  elem_t                 taps_elem;
  elem_t                 step_out;
  elem_t                 sum;
  step_req_t             step_req;
  logic [BPAD_W-1:0]     base_pad;
  logic [EXP_BITS+EXPONENT_W-1:0] exp_pad;
  logic [DEGREE+TAPS_W-1:0]       taps_pad;
  logic [FIELD_W+DEGREE-1:0]      sum_pad;
  logic                  out_free;

  // tap bits at or above the degree take no part
  assign taps_pad  = (DEGREE + TAPS_W)'(taps_q);
  assign taps_elem = taps_pad[DEGREE-1:0];
  assign exp_pad   = (EXP_BITS + EXPONENT_W)'(term_i.exponent);
  assign base_pad  = BPAD_W'(base_q);
  assign sum       = acc_q ^ base_q;
  assign sum_pad   = (FIELD_W + DEGREE)'(sum);
  assign out_free  = !out_valid_q || result_o.ready;

  always_comb begin
    step_req.part = part_q;
    step_req.base = base_q;
    step_req.bits = base_pad[chunk_q*STEP_BITS +: STEP_BITS];
    step_req.taps = taps_elem;
    step_req.do_x = (chunk_q == '0) && exp_q[bit_q];
  end

  gf2mmr_mul_step u_step (
    .req_i  (step_req),
    .part_o (step_out)
  );

  assign term_i.ready           = (state_q == ST_IDLE);
  assign result_o.valid         = out_valid_q;
  assign result_o.field_element = out_data_q;

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    base_d      = base_q;
    part_d      = part_q;
    exp_d       = exp_q;
    last_d      = last_q;
    bit_d       = bit_q;
    chunk_d     = chunk_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (term_i.valid) begin
          base_d  = elem_t'(1);
          part_d  = '0;
          exp_d   = exp_pad[EXP_BITS-1:0];
          last_d  = term_i.last_term;
          bit_d   = BIT_IDX_W'(EXP_BITS - 1);
          chunk_d = CHUNK_W'(NCHUNK - 1);
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (chunk_q == '0) begin
          // square (and optional times x) done for this exponent bit
          base_d  = step_out;
          part_d  = '0;
          chunk_d = CHUNK_W'(NCHUNK - 1);
          if (bit_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            bit_d = bit_q - 1'b1;
          end
        end else begin
          part_d  = step_out;
          chunk_d = chunk_q - 1'b1;
        end
      end
      ST_FINISH: begin
        if (!last_q) begin
          acc_d   = sum;
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = sum_pad[FIELD_W-1:0];
          acc_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      taps_q      <= TAPS_RESET;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
      chunk_q     <= '0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
      chunk_q     <= chunk_d;
      if (cfg_we_i) begin
        taps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    part_q     <= part_d;
    exp_q      <= exp_d;
    last_q     <= last_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

// ----- hdl/gf2mmr_checker.sv -----
`default_nettype none

module gf2mmr_checker import gf2mmr_pkg::*; (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               term_valid_i,
  input wire               term_ready_i,
  input wire               res_valid_i,
  input wire               res_ready_i,
  input wire [FIELD_W-1:0] res_data_i
);

  logic term_acc;
  assign term_acc = term_valid_i && term_ready_i;

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_data_i))
    else $error("result data changed while stalled");

  // a taken request keeps the block busy at the start of its exponent walk
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_acc |=> !term_ready_i ##1 !term_ready_i)
    else $error("request taken while a term is in work");

  a_busy_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_acc |=> ##8 !term_ready_i)
    else $error("term finished too early");

  // a new result only comes out of a busy cycle
  a_res_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> !$past(term_ready_i))
    else $error("result appeared without a term in work");

endmodule

bind gf2m_monomial_sum_reducer_unit gf2mmr_checker u_gf2mmr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .term_valid_i (term_i.valid),
  .term_ready_i (term_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_data_i   (result_o.field_element)
);

`default_nettype wire
